### hw/rtl/dsrs_pkg.sv
// ----------------------------------------------------------------------------
// Display shift-register serializer package
// Beat types, frame constants and internal state record shared by the
// serializer step logic and the top level.
// ----------------------------------------------------------------------------
package dsrs_pkg;

  localparam int unsigned FrameBits = 14;
  localparam int unsigned CountW    = 5;

  localparam logic [CountW-1:0] FrameEnd = CountW'(FrameBits);
  localparam logic [CountW-1:0] LatchEnd = CountW'(17);

  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_START = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] segment_byte;
    logic [1:0] select_bits;
    logic [1:0] status_bits;
  } in_t;

  typedef struct packed {
    logic serial_data;
    logic shift_clock;
    logic latch_clock;
    logic output_disable;
    logic busy_res;
    logic frame_done;
  } out_t;

  typedef struct packed {
    logic                 clock_phase;
    logic                 active;
    logic [CountW-1:0]    bit_count;
    logic                 bit_clocked;
    logic                 seen_low_phase;
    logic [FrameBits-1:0] frame_shift;
    logic                 serial_data;
    logic                 shift_clock;
    logic                 latch_clock;
    logic                 output_disable;
  } state_t;

  localparam state_t StateReset = '{
    clock_phase:    1'b0,
    active:         1'b0,
    bit_count:      '0,
    bit_clocked:    1'b1,
    seen_low_phase: 1'b0,
    frame_shift:    '0,
    serial_data:    1'b0,
    shift_clock:    1'b0,
    latch_clock:    1'b0,
    output_disable: 1'b0
  };

  // Bit 0 is sent first: select MSB first, status MSB first, then the
  // segment byte LSB first with a zero pad after bit 0 and after bit 7.
  function automatic logic [FrameBits-1:0] build_frame(input logic [7:0] seg,
                                                       input logic [1:0] sel,
                                                       input logic [1:0] sts);
    logic [FrameBits-1:0] f;
    f = {1'b0, seg[7:1], 1'b0, seg[0], sts[0], sts[1], sel[0], sel[1]};
    return f;
  endfunction

endpackage

### hw/rtl/dsrs_step.sv
// ----------------------------------------------------------------------------
// Serializer step logic
// Computes the next state and the line levels for one tick or start beat.
// ----------------------------------------------------------------------------
module dsrs_step (
  input  dsrs_pkg::state_t state_i,
  input  dsrs_pkg::in_t    beat_i,
  output dsrs_pkg::state_t state_o,
  output dsrs_pkg::out_t   res_o
);

  always_comb begin
    dsrs_pkg::state_t s;
    logic done;
    logic go_on;
    logic shifting;

    s        = state_i;
    done     = 1'b0;
    go_on    = 1'b1;
    shifting = 1'b0;

    if (beat_i.mode == dsrs_pkg::MODE_START) begin
      if (!s.active) begin
        s.frame_shift    = dsrs_pkg::build_frame(beat_i.segment_byte, beat_i.select_bits,
                                                 beat_i.status_bits);
        s.active         = 1'b1;
        s.bit_count      = '0;
        s.bit_clocked    = 1'b1;
        s.seen_low_phase = 1'b0;
      end
    end else begin
      s.clock_phase = ~s.clock_phase;
    end

    if (s.active) begin
      shifting = (s.bit_count < dsrs_pkg::FrameEnd) ||
                 ((s.bit_count == dsrs_pkg::FrameEnd) && !s.bit_clocked);
      if (shifting) begin
        if (!s.clock_phase) begin
          go_on            = 1'b0;
          s.seen_low_phase = 1'b1;
          if (s.bit_clocked) begin
            s.serial_data = s.frame_shift[0];
            s.frame_shift = s.frame_shift >> 1;
            s.shift_clock = 1'b0;
            s.bit_count   = s.bit_count + 1'b1;
            s.bit_clocked = 1'b0;
          end
        end else if (!s.seen_low_phase || s.bit_clocked) begin
          go_on = 1'b0;
        end else begin
          s.shift_clock = 1'b1;
          s.bit_clocked = 1'b1;
          if (s.bit_count != dsrs_pkg::FrameEnd) begin
            go_on = 1'b0;
          end else begin
            // Last bit clocked: blank the outputs and raise the latch clock.
            s.output_disable = 1'b1;
            s.latch_clock    = 1'b1;
          end
        end
      end

      // Latch hold: count high phases until the hold ends.
      if (go_on) begin
        if (s.clock_phase) begin
          if (s.bit_clocked) begin
            s.bit_count   = s.bit_count + 1'b1;
            s.bit_clocked = 1'b0;
            if (s.bit_count >= dsrs_pkg::LatchEnd) begin
              s.output_disable = 1'b0;
              s.shift_clock    = 1'b0;
              s.latch_clock    = 1'b0;
              s.active         = 1'b0;
              done             = 1'b1;
            end
          end
        end else begin
          s.bit_clocked = 1'b1;
        end
      end
    end

    state_o = s;

    res_o.serial_data    = s.serial_data;
    res_o.shift_clock    = s.shift_clock;
    res_o.latch_clock    = s.latch_clock;
    res_o.output_disable = s.output_disable;
    res_o.busy_res       = s.active;
    res_o.frame_done     = done;
  end

endmodule

### hw/rtl/display_shift_register_serializer_top.sv
// ----------------------------------------------------------------------------
// Display shift-register serializer
// Generates the data, shift clock, latch clock and output enable levels for
// an external serial-in, latched-output shift register driving a display.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is either a timer tick (mode 0) that toggles the internal
//   clock phase, or a start (mode 1) that loads a 14-bit frame built from the
//   select, status and segment fields. A start while a frame is in flight is
//   ignored. Every input beat produces exactly one output beat carrying the
//   line levels, the busy flag and a done flag on the beat ending the latch.
//   The state and result registers are written at the edge that accepts the
//   beat, and the result is valid the next cycle.
//   Throughput is one beat per cycle while the receiver keeps up; the whole
//   step is a single pass of logic between the state and result registers.
//   A result that waits for the receiver does not block the input as long as
//   the receiver takes it in the same cycle; while the receiver stalls with a
//   result pending, in_ready_o stays low and nothing is lost.
//   Reset returns the phase to low, the block to idle and all lines low.
// ----------------------------------------------------------------------------
module display_shift_register_serializer_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dsrs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dsrs_pkg::out_t out_data_o
);

  dsrs_pkg::state_t state_q, state_d;
  dsrs_pkg::out_t   res_d, res_q;
  logic             out_valid_q;
  logic             in_fire;

  dsrs_step u_step (
    .state_i (state_q),
    .beat_i  (in_data_i),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsrs_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule
